@@ hw/rtl/chd_pkg.sv @@
package chd_pkg;

   localparam int SIZE_BITS = 24;
   localparam int BASE_HEX_BITS = 4;

   localparam logic [7:0] CR_BYTE = 8'h0D;
   localparam logic [7:0] LF_BYTE = 8'h0A;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   // one classified body byte, as it waits between front and back
   typedef struct packed {
      logic [7:0]               body_byte;
      logic                     end_of_buffer;
      logic                     is_cr;
      logic                     is_lf;
      logic                     is_hex;
      logic [BASE_HEX_BITS-1:0] hex_val;
   } item_type;

   // {is_hex, digit value}
   function automatic logic [BASE_HEX_BITS:0] hex_value(input logic [7:0] b);
      logic [BASE_HEX_BITS:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/chd_if.sv @@
interface chd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       end_of_buffer;

   modport source (output valid, output body_byte, output end_of_buffer, input ready);
   modport sink (input valid, input body_byte, input end_of_buffer, output ready);
endinterface

interface chd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [1:0] result_kind;

   modport source (output valid, output payload_byte, output result_kind, input ready);
   modport sink (input valid, input payload_byte, input result_kind, output ready);
endinterface

@@ hw/rtl/http_chunked_deframer.sv @@
// Chunked transfer decoder for an HTTP/1.1 response body. Feed the body bytes
// that follow the header on req_ch, one byte per item, with end_of_buffer set on
// the last byte of the buffer. rsp_ch returns each payload byte (kind 0), then a
// single done (kind 1) at the zero-size chunk, or a single error (kind 2) if the
// buffer ends early or a chunk size exceeds 24 bits; after done or error all
// further bytes are swallowed until reset. Throughput is one byte per clock while
// rsp_ch does not stall: a front stage classifies each byte into a four-entry
// queue, and the back-end state machine consumes one queued byte per cycle into
// a registered output when it is free. A byte is stored in the queue, then in the
// output register; the queue absorbs stalls so req_ch stays ready until it fills.
module http_chunked_deframer (
   input  logic      clock,
   input  logic      reset,
   chd_req_if.sink   req_ch,
   chd_rsp_if.source rsp_ch
);

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_not_empty;
   chd_pkg::item_type push_item;
   chd_pkg::item_type pop_item;

   chd_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   chd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (pop_item)
   );

   chd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .item            (pop_item),
      .pop             (pop),
      .rsp_ch          (rsp_ch)
   );

endmodule

@@ hw/rtl/chd_front.sv @@
module chd_front (
   chd_req_if.sink             req_ch,
   input  logic                queue_full,
   output logic                push,
   output chd_pkg::item_type   push_item
);

   logic [chd_pkg::BASE_HEX_BITS:0] hex;

   assign hex = chd_pkg::hex_value(req_ch.body_byte);

   assign req_ch.ready = !queue_full;
   assign push = req_ch.valid && !queue_full;

   always_comb begin
      push_item.body_byte     = req_ch.body_byte;
      push_item.end_of_buffer = req_ch.end_of_buffer;
      push_item.is_cr         = (req_ch.body_byte == chd_pkg::CR_BYTE);
      push_item.is_lf         = (req_ch.body_byte == chd_pkg::LF_BYTE);
      push_item.is_hex        = hex[chd_pkg::BASE_HEX_BITS];
      push_item.hex_val       = hex[chd_pkg::BASE_HEX_BITS-1:0];
   end

endmodule

@@ hw/rtl/chd_queue.sv @@
module chd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  chd_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output chd_pkg::item_type pop_item
);

   chd_pkg::item_type mem_ff [chd_pkg::QUEUE_DEPTH];

   logic [chd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [chd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [chd_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full      = (count_ff == (chd_pkg::QUEUE_PTR_BITS+1)'(chd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/chd_back.sv @@
module chd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_not_empty,
   input  chd_pkg::item_type item,
   output logic              pop,
   chd_rsp_if.source         rsp_ch
);

   typedef enum logic [6:0] {
      PH_LINE     = 7'b0000001,
      PH_LINE_CR  = 7'b0000010,
      PH_DATA     = 7'b0000100,
      PH_TRAIL_CR = 7'b0001000,
      PH_TRAIL_LF = 7'b0010000,
      PH_DONE     = 7'b0100000,
      PH_ERROR    = 7'b1000000
   } phase_type;

   localparam int SB = chd_pkg::SIZE_BITS;
   localparam int HB = chd_pkg::BASE_HEX_BITS;

   phase_type         phase_ff, phase_in;
   logic [SB-1:0]     acc_ff, acc_in;
   logic              closed_ff, closed_in;
   logic [SB-1:0]     left_ff, left_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        pay_ff, pay_in;
   chd_pkg::kind_type kind_ff, kind_in;

   logic              out_free;
   logic              have;
   logic              ok;
   logic              run_line;
   logic [SB-1:0]     lb_acc;
   logic              lb_closed;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop      = queue_not_empty && out_free;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.payload_byte = pay_ff;
   assign rsp_ch.result_kind  = kind_ff;

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      closed_in = closed_ff;
      left_in   = left_ff;
      have      = 1'b0;
      ok        = 1'b1;
      kind_in   = chd_pkg::KIND_PAYLOAD;
      pay_in    = '0;
      run_line  = 1'b0;
      lb_acc    = acc_ff;
      lb_closed = closed_ff;

      case (phase_ff)
         PH_LINE: begin
            run_line = 1'b1;
         end
         PH_LINE_CR: begin
            if (item.is_lf) begin
               if (acc_ff == '0) begin
                  phase_in = PH_DONE;
                  have     = 1'b1;
                  kind_in  = chd_pkg::KIND_DONE;
               end else begin
                  left_in   = acc_ff;
                  acc_in    = '0;
                  closed_in = 1'b0;
                  phase_in  = PH_DATA;
               end
            end else if (!item.is_cr) begin
               phase_in = PH_LINE;
            end
         end
         PH_DATA: begin
            have    = 1'b1;
            pay_in  = item.body_byte;
            // a chunk holds at least one byte here, so one left means this is the last
            left_in = left_ff - SB'(1);
            if (left_ff <= SB'(1)) begin
               left_in  = '0;
               phase_in = PH_TRAIL_CR;
            end
         end
         PH_TRAIL_CR: begin
            if (item.is_cr) begin
               phase_in = PH_TRAIL_LF;
            end else begin
               run_line  = 1'b1;
               lb_acc    = '0;
               lb_closed = 1'b0;
            end
         end
         PH_TRAIL_LF: begin
            if (item.is_lf) begin
               phase_in  = PH_LINE;
               acc_in    = '0;
               closed_in = 1'b0;
            end else begin
               // the lone CR opened a line with no digits
               run_line  = 1'b1;
               lb_acc    = '0;
               lb_closed = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (run_line) begin
         phase_in  = PH_LINE;
         acc_in    = lb_acc;
         closed_in = lb_closed;
         if (item.is_cr) begin
            closed_in = 1'b1;
            phase_in  = PH_LINE_CR;
         end else if (!lb_closed && item.is_hex) begin
            if (lb_acc[SB-1 -: HB] != '0) begin
               ok = 1'b0;
            end else begin
               acc_in = {lb_acc[SB-HB-1:0], item.hex_val};
            end
         end else begin
            closed_in = 1'b1;
         end
      end

      if (phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
         if (!ok || (item.end_of_buffer && phase_in != PH_DONE)) begin
            phase_in = PH_ERROR;
            have     = 1'b1;
            kind_in  = chd_pkg::KIND_ERROR;
            pay_in   = '0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = have;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE;
         acc_ff       <= '0;
         closed_ff    <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            closed_ff <= closed_in;
            left_ff   <= left_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && have) begin
         pay_ff  <= pay_in;
         kind_ff <= kind_in;
      end
   end

endmodule
